FILE: rtl/core/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// shared types and codes of the voxel face culler: sequencer states, request
// actions, face directions and configuration register indexes
// ----------------------------------------------------------------------------
package vfc_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_CODE,
    ST_NBR,
    ST_EMIT
  } vfc_state_t;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_MESH  = 2'd2;

  localparam logic [2:0] DIR_PX = 3'd0;
  localparam logic [2:0] DIR_NX = 3'd1;
  localparam logic [2:0] DIR_PY = 3'd2;
  localparam logic [2:0] DIR_NY = 3'd3;
  localparam logic [2:0] DIR_PZ = 3'd4;
  localparam logic [2:0] DIR_NZ = 3'd5;

  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Z = 1'b1;

  localparam int ORIGIN_BITS = 21;
  localparam int WORLD_BITS  = 25;

endpackage

FILE: rtl/core/voxel_face_culler_unit.sv
// ----------------------------------------------------------------------------
// voxel_face_culler_unit
// after reset the store is swept to air, one cell a cycle, with requests stalled;
// write: done in the idle state; read, or mesh of an air cell: cell read, result
// loaded in the code state; mesh of a solid cell: six neighbour reads, a result per
// visible face (one with face_valid low if none); one store read per cell and
// neighbour, one result a cycle unless rsp_stall holds it, one request at a time
// ----------------------------------------------------------------------------
module voxel_face_culler_unit import vfc_pkg::*; #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_LAYERS = 256,
  parameter int TYPE_BITS    = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ORIGIN_BITS-1:0]       cfg_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   action,
  input  logic [3:0]                   block_x,
  input  logic [7:0]                   block_y,
  input  logic [3:0]                   block_z,
  input  logic [7:0]                   write_type,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         face_valid,
  output logic [2:0]                   face_dir,
  output logic [7:0]                   block_code,
  output logic signed [WORLD_BITS-1:0] world_x,
  output logic [7:0]                   world_y,
  output logic signed [WORLD_BITS-1:0] world_z,
  output logic                         last
);

  localparam int XB = $clog2(CHUNK_WIDTH);
  localparam int YB = $clog2(CHUNK_LAYERS);
  localparam int AW = YB + 2 * XB;

  vfc_state_t st, st_next;

  logic [ORIGIN_BITS-1:0] origin_x, origin_z;
  logic [1:0] act;
  logic [3:0] cx, cz;
  logic [7:0] cy;
  logic signed [WORLD_BITS-1:0] wx, wz;
  logic [TYPE_BITS-1:0] code, code_next;
  logic [5:0] mask, mask_next;
  logic [2:0] dir, dir_next;
  logic [AW-1:0] clr_addr;

  logic signed [WORLD_BITS-1:0] ox_wide, oz_wide, wx_calc, wz_calc;

  logic accept, out_free, cell_inside, in_inside;
  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [TYPE_BITS-1:0] wr_data, rd_data;

  logic out_load, o_valid, o_last;
  logic [2:0] o_dir, pick;
  logic [TYPE_BITS-1:0] o_code;
  logic o_pos;

  function automatic logic [AW-1:0] nbr_addr(input logic [2:0] d);
    logic [XB-1:0] ax;
    logic [YB-1:0] ay;
    logic [XB-1:0] az;
    ax = XB'(cx);
    ay = YB'(cy);
    az = XB'(cz);
    case (d)
      DIR_PX: ax = ax + XB'(1);
      DIR_NX: ax = ax - XB'(1);
      DIR_PY: ay = ay + YB'(1);
      DIR_NY: ay = ay - YB'(1);
      DIR_PZ: az = az + XB'(1);
      DIR_NZ: az = az - XB'(1);
      default: ax = XB'(cx);
    endcase
    return {ay, az, ax};
  endfunction

  function automatic logic nbr_inside(input logic [2:0] d);
    logic r;
    case (d)
      DIR_PX: r = (int'(cx) + 1) < CHUNK_WIDTH;
      DIR_NX: r = cx != 4'd0;
      DIR_PY: r = (int'(cy) + 1) < CHUNK_LAYERS;
      DIR_NY: r = cy != 8'd0;
      DIR_PZ: r = (int'(cz) + 1) < CHUNK_WIDTH;
      DIR_NZ: r = cz != 4'd0;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  vfc_store #(
    .AW(AW),
    .DW(TYPE_BITS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // world position from chunk origin
  assign ox_wide = {{(WORLD_BITS-ORIGIN_BITS){origin_x[ORIGIN_BITS-1]}}, origin_x};
  assign oz_wide = {{(WORLD_BITS-ORIGIN_BITS){origin_z[ORIGIN_BITS-1]}}, origin_z};
  assign wx_calc = WORLD_BITS'(ox_wide * WORLD_BITS'(CHUNK_WIDTH))
                   + WORLD_BITS'(block_x);
  assign wz_calc = WORLD_BITS'(oz_wide * WORLD_BITS'(CHUNK_WIDTH))
                   + WORLD_BITS'(block_z);

  assign req_stall   = (st != ST_IDLE);
  assign accept      = req_valid && !req_stall;
  assign out_free    = !rsp_valid || !rsp_stall;
  assign cell_inside = (int'(cx) < CHUNK_WIDTH) && (int'(cy) < CHUNK_LAYERS)
                       && (int'(cz) < CHUNK_WIDTH);
  assign in_inside   = (int'(block_x) < CHUNK_WIDTH) && (int'(block_y) < CHUNK_LAYERS)
                       && (int'(block_z) < CHUNK_WIDTH);

  always_comb begin
    pick = DIR_PX;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) begin
        pick = 3'(i);
      end
    end
  end

  always_comb begin
    st_next   = st;
    code_next = code;
    mask_next = mask;
    dir_next  = dir;
    wr_en     = 1'b0;
    wr_addr   = {YB'(block_y), XB'(block_z), XB'(block_x)};
    wr_data   = TYPE_BITS'(write_type);
    rd_en     = 1'b0;
    rd_addr   = {YB'(cy), XB'(cz), XB'(cx)};
    out_load  = 1'b0;
    o_valid   = 1'b0;
    o_dir     = DIR_PX;
    o_code    = '0;
    o_pos     = 1'b0;
    o_last    = 1'b1;
    case (st)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == '1) begin
          st_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_WRITE: wr_en = in_inside;
            ACT_READ:  st_next = ST_CELL;
            ACT_MESH:  st_next = ST_CELL;
            default:   st_next = ST_IDLE;
          endcase
        end
      end
      ST_CELL: begin
        rd_en   = 1'b1;
        st_next = ST_CODE;
      end
      ST_CODE: begin
        code_next = cell_inside ? rd_data : '0;
        if (act == ACT_MESH && code_next != '0) begin
          rd_en     = 1'b1;
          rd_addr   = nbr_addr(DIR_PX);
          dir_next  = DIR_PX;
          mask_next = '0;
          st_next   = ST_NBR;
        end else if (out_free) begin
          out_load = 1'b1;
          o_valid  = (act == ACT_READ);
          o_code   = code_next;
          o_pos    = (act == ACT_READ);
          st_next  = ST_IDLE;
        end
      end
      ST_NBR: begin
        mask_next[dir] = !nbr_inside(dir) || (rd_data == '0);
        if (dir == DIR_NZ) begin
          st_next = ST_EMIT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = nbr_addr(dir + 3'd1);
          dir_next = dir + 3'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (mask == '0) begin
            st_next = ST_IDLE;
          end else begin
            o_valid         = 1'b1;
            o_dir           = pick;
            o_code          = code;
            o_pos           = 1'b1;
            o_last          = (mask & (mask - 6'd1)) == '0;
            mask_next[pick] = 1'b0;
            if (o_last) begin
              st_next = ST_IDLE;
            end
          end
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_CLEAR;
      clr_addr <= '0;
      origin_x <= '0;
      origin_z <= '0;
      rsp_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we && cfg_index == REG_ORIGIN_X) begin
        origin_x <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_ORIGIN_Z) begin
        origin_z <= cfg_data;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action;
      cx  <= block_x;
      cy  <= block_y;
      cz  <= block_z;
      wx  <= wx_calc;
      wz  <= wz_calc;
    end
    code <= code_next;
    mask <= mask_next;
    dir  <= dir_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      face_valid <= o_valid;
      face_dir   <= o_dir;
      block_code <= 8'(o_code);
      world_x    <= o_pos ? wx : '0;
      world_y    <= o_pos ? cy : 8'd0;
      world_z    <= o_pos ? wz : '0;
      last       <= o_last;
    end
  end

endmodule

FILE: rtl/core/vfc_store.sv
// ----------------------------------------------------------------------------
// vfc_store
// simple dual-port block code memory: one write and one registered read a cycle
// ----------------------------------------------------------------------------
module vfc_store #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
